[hw/rtl/mrfi_pkg.sv]
// Shared operation and status codes for the message ring with front insert.
`default_nettype none
package mrfi_pkg;

   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP        = 2'd2,
      OP_FLUSH      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/mrfi_store.sv]
// Message store: single write port, single read port with registered read data.
`default_nettype none
module mrfi_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/message_ring_with_front_insert.sv]
// Top level of the message ring with front insert.
// The block takes one operation per clock cycle unless req_stall is high: push back,
// push front, pop or flush. Each transaction gives exactly one result, through the result
// stage and then the output register; the pop data comes from the registered read of the
// message store, and the result stage plus the output register hold up to two finished
// results, so a stalled result side blocks the request side only once both are occupied.
// Indices and the count update in the cycle of acceptance, so back-to-back operations see
// each other without forwarding. The capacity register (values 0 and above DEPTH act as 1
// and DEPTH) is to be written by the user only while no transaction is in flight; the block
// itself does not enforce this. The store needs no clearing pass after reset.
`default_nettype none
module message_ring_with_front_insert
   import mrfi_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int MSG_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_operation,
   input  wire logic [MSG_WIDTH-1:0]         req_message_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [1:0]                   rsp_status,
   output logic      [MSG_WIDTH-1:0]         rsp_message_out,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_stored_count,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [$clog2(DEPTH+1)-1:0]   csr_data
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [CntW-1:0] capacity_ff;
   logic [CntW-1:0] cap;

   logic [IdxW-1:0] rd_idx_ff, rd_idx_in;
   logic [IdxW-1:0] wr_idx_ff, wr_idx_in;
   logic [CntW-1:0] count_ff, count_in;

   logic            s1_valid_ff, s1_valid_in;
   status_type      s1_status_ff, s1_status_in;
   logic            s1_pop_ok_ff, s1_pop_ok_in;
   logic [CntW-1:0] s1_count_ff, s1_count_in;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [MSG_WIDTH-1:0] rsp_message_ff;
   logic [CntW-1:0]      rsp_count_ff;

   logic                 req_accept;
   logic                 rsp_free;
   logic                 s1_advance;
   op_type               op;
   logic                 mem_wr_en;
   logic [IdxW-1:0]      mem_wr_addr;
   logic                 mem_rd_en;
   logic [MSG_WIDTH-1:0] mem_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CntW'(DEPTH);
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   always_comb begin
      if (capacity_ff == '0) begin
         cap = CntW'(1);
      end else if (capacity_ff > CntW'(DEPTH)) begin
         cap = CntW'(DEPTH);
      end else begin
         cap = capacity_ff;
      end
   end

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign op         = op_type'(req_operation);

   always_comb begin
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      count_in     = count_ff;
      s1_status_in = ST_OK;
      s1_pop_ok_in = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_idx_ff;
      mem_rd_en    = 1'b0;
      if (req_accept) begin
         unique case (op)
            OP_PUSH_BACK: begin
               if (count_ff >= cap) begin
                  s1_status_in = ST_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  if ((CntW'(wr_idx_ff) + CntW'(1)) >= cap) begin
                     wr_idx_in = '0;
                  end else begin
                     wr_idx_in = wr_idx_ff + IdxW'(1);
                  end
                  count_in = count_ff + CntW'(1);
               end
            end
            OP_PUSH_FRONT: begin
               if (count_ff >= cap) begin
                  s1_status_in = ST_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  if (rd_idx_ff == '0) begin
                     rd_idx_in = IdxW'(cap - CntW'(1));
                  end else begin
                     rd_idx_in = rd_idx_ff - IdxW'(1);
                  end
                  mem_wr_addr = rd_idx_in;
                  count_in    = count_ff + CntW'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  mem_rd_en    = 1'b1;
                  s1_pop_ok_in = 1'b1;
                  if ((CntW'(rd_idx_ff) + CntW'(1)) >= cap) begin
                     rd_idx_in = '0;
                  end else begin
                     rd_idx_in = rd_idx_ff + IdxW'(1);
                  end
                  count_in = count_ff - CntW'(1);
               end
            end
            OP_FLUSH: begin
               rd_idx_in = '0;
               wr_idx_in = '0;
               count_in  = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      s1_count_in = count_in;
      s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
   end

   mrfi_store #(
      .DEPTH (DEPTH),
      .WIDTH (MSG_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_message_in),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff   <= rd_idx_in;
         wr_idx_ff   <= wr_idx_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= s1_status_in;
         s1_pop_ok_ff <= s1_pop_ok_in;
         s1_count_ff  <= s1_count_in;
      end
      if (s1_advance) begin
         rsp_status_ff  <= s1_status_ff;
         rsp_message_ff <= s1_pop_ok_ff ? mem_rd_data : '0;
         rsp_count_ff   <= s1_count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_message_out  = rsp_message_ff;
   assign rsp_stored_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("held count above depth");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op == OP_FLUSH) |=> (count_ff == '0 && rd_idx_ff == '0
                                          && wr_idx_ff == '0))
      else $error("flush did not clear indices and count");

   a_refused_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_message_ff == '0))
      else $error("refused operation carries message data");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_count_ff)))
      else $error("result stage lost a held transaction");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op == OP_POP && count_ff != '0) |=>
         (count_ff == $past(count_ff) - CntW'(1)))
      else $error("pop did not decrement count");
`endif

endmodule
`default_nettype wire

[tb/tb_message_ring_with_front_insert.sv]
// Self-checking testbench for the message ring with front insert.
module tb_message_ring_with_front_insert
   import mrfi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = 16;
   localparam int PHASES     = 19;
   localparam int PHASE_OPS  = 50;

   typedef struct packed {
      status_type  status;
      logic [31:0] msg;
      logic [4:0]  count;
   } ring_result_type;

   typedef struct packed {
      op_type          op;
      logic [31:0]     msg;
      logic            typed;
      ring_result_type want;
   } script_row_type;

   localparam script_row_type SCRIPT [26] = '{
      '{OP_POP,        32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0}},
      '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 5'd1}},
      '{OP_POP,        32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{OP_FLUSH,      32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 5'd1}},
      '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 5'd2}},
      '{OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b1, '{ST_OK,    32'h0000_0000, 5'd3}},
      '{OP_PUSH_BACK,  32'h5555_5555, 1'b1, '{ST_OK,    32'h0000_0000, 5'd4}},
      '{OP_PUSH_BACK,  32'h8000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 5'd5}},
      '{OP_PUSH_BACK,  32'h0000_0001, 1'b1, '{ST_OK,    32'h0000_0000, 5'd6}},
      '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 5'd7}},
      '{OP_PUSH_BACK,  32'hFFFF_FFFE, 1'b1, '{ST_OK,    32'h0000_0000, 5'd8}},
      '{OP_PUSH_BACK,  32'h0F0F_0F0F, 1'b1, '{ST_OK,    32'h0000_0000, 5'd9}},
      '{OP_PUSH_BACK,  32'hF0F0_F0F0, 1'b1, '{ST_OK,    32'h0000_0000, 5'd10}},
      '{OP_PUSH_BACK,  32'h0123_4567, 1'b1, '{ST_OK,    32'h0000_0000, 5'd11}},
      '{OP_PUSH_BACK,  32'h89AB_CDEF, 1'b1, '{ST_OK,    32'h0000_0000, 5'd12}},
      '{OP_PUSH_BACK,  32'h1357_9BDF, 1'b1, '{ST_OK,    32'h0000_0000, 5'd13}},
      '{OP_PUSH_BACK,  32'h2468_ACE0, 1'b1, '{ST_OK,    32'h0000_0000, 5'd14}},
      '{OP_PUSH_BACK,  32'hCAFE_F00D, 1'b1, '{ST_OK,    32'h0000_0000, 5'd15}},
      '{OP_PUSH_BACK,  32'h0BAD_C0DE, 1'b1, '{ST_OK,    32'h0000_0000, 5'd16}},
      '{OP_PUSH_BACK,  32'h1234_5678, 1'b1, '{ST_FULL,  32'h0000_0000, 5'd16}},
      '{OP_PUSH_FRONT, 32'h8765_4321, 1'b1, '{ST_FULL,  32'h0000_0000, 5'd16}},
      '{OP_POP,        32'h0000_0000, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 5'd15}},
      '{OP_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{OP_POP,        32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
      '{OP_POP,        32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [31:0] req_message_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_message_out;
   logic [4:0]  rsp_stored_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_data;

   // ring image and capacity register as the block should hold them
   logic [31:0]  ring_store [RING_DEPTH];
   int           read_slot;
   int           write_slot;
   int           held;
   logic [4:0]   capacity_reg;

   ring_result_type replies_due [$];
   int              mismatch_count = 0;
   int              burst_left = 0;
   bit              steady = 1'b0;
   bit              long_hold_req = 1'b0;

   message_ring_with_front_insert #(
      .DEPTH     (RING_DEPTH),
      .MSG_WIDTH (32)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_message_in   (req_message_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_message_out  (rsp_message_out),
      .rsp_stored_count (rsp_stored_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   function automatic ring_result_type ring_apply(input op_type op, input logic [31:0] msg);
      ring_result_type r;
      int              cap;
      r   = '{ST_OK, 32'h0, 5'd0};
      cap = (capacity_reg == 5'd0) ? 1 :
            ((int'(capacity_reg) > RING_DEPTH) ? RING_DEPTH : int'(capacity_reg));
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (held >= cap) begin
               r.status = ST_FULL;
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  read_slot = (read_slot == 0) ? cap - 1 : read_slot - 1;
                  ring_store[read_slot] = msg;
               end else begin
                  ring_store[write_slot] = msg;
                  write_slot = (write_slot + 1 >= cap) ? 0 : write_slot + 1;
               end
               held++;
            end
         end
         OP_POP: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.msg = ring_store[read_slot];
               read_slot = (read_slot + 1 >= cap) ? 0 : read_slot + 1;
               held--;
            end
         end
         default: begin
            read_slot  = 0;
            write_slot = 0;
            held       = 0;
         end
      endcase
      r.count = held[4:0];
      return r;
   endfunction

   task automatic offer(input op_type op, input logic [31:0] msg, input logic typed,
                        input ring_result_type given);
      ring_result_type r;
      int              gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_message_in <= msg;
      do @(posedge clock); while (req_stall);
      r = ring_apply(op, msg);
      replies_due.push_back(typed ? given : r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 16);
         if (!steady) begin
            gap = $urandom_range(1, 5);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : reply_check
      ring_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected transaction status=%0d message=%h count=%0d",
                     $time, rsp_status, rsp_message_out, rsp_stored_count);
            mismatch_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_message_out !== want.msg) begin
               $display("%0t: message expected %h actual %h", $time, want.msg, rsp_message_out);
               mismatch_count++;
            end
            if (rsp_stored_count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count,
                        rsp_stored_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : rsp_side
      int mode;
      int span;
      int hold_left;
      mode      = 0;
      span      = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 80;
            rsp_stall <= 1'b1;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(8, 64);
            end
            span--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      #400_000;
      $display("** message_ring_with_front_insert: FAILED **");
      $finish;
   end

   initial begin
      op_type      op;
      logic [4:0]  new_cap;
      int          push_pct;
      int          pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_PUSH_BACK;
      req_message_in = 32'h0;
      csr_valid      = 1'b0;
      csr_data       = 5'd0;
      for (int i = 0; i < RING_DEPTH; i++) ring_store[i] = 32'h0;
      read_slot    = 0;
      write_slot   = 0;
      held         = 0;
      capacity_reg = 5'd16;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) offer(SCRIPT[i].op, SCRIPT[i].msg, SCRIPT[i].typed, SCRIPT[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: new_cap = 5'd1;
            1: new_cap = 5'd0;
            2: new_cap = 5'd16;
            3: new_cap = 5'd31;
            4: new_cap = 5'd17;
            5: new_cap = 5'd2;
            6: new_cap = 5'd16;
            7: new_cap = 5'd8;
            default: new_cap = 5'($urandom_range(0, 31));
         endcase
         write_capacity(new_cap);
         steady   = (phase % 4 == 1);
         push_pct = (phase % 3 == 0) ? 65 : ((phase % 3 == 1) ? 45 : 25);
         if (phase == 6) begin
            steady        = 1'b1;
            long_hold_req = 1'b1;
         end
         for (int n = 0; n < PHASE_OPS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) op = OP_FLUSH;
            else if (pick < 3 + push_pct)
               op = ($urandom_range(0, 1) == 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else op = OP_POP;
            offer(op, $urandom, 1'b0, '{ST_OK, 32'h0, 5'd0});
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** message_ring_with_front_insert: PASSED **");
      end else begin
         $display("** message_ring_with_front_insert: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/mrfi_pkg.sv
hw/rtl/mrfi_store.sv
hw/rtl/message_ring_with_front_insert.sv
tb/tb_message_ring_with_front_insert.sv
